>>> rtl/core/rrss_pkg.sv
// ============================================================================
// rrss_pkg: shared types and constants for the round-robin sleep scheduler
// Transaction payloads, action and status codes, and the sequencer states.
// ============================================================================
package rrss_pkg;

  // Table size default and fixed field widths
  localparam int MAX_THREADS_DEF = 16;
  localparam int SLOT_W          = 4;
  localparam int WORD_W          = 64;

  // Action codes
  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_SLEEP  = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_NO_RUN  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [WORD_W-1:0] context_word;
    logic [WORD_W-1:0] now;
    logic [WORD_W-1:0] wake_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] resume_context;
    logic              ran_idle;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR_RD,
    ST_CR_WR1,
    ST_CR_WR2,
    ST_T_START,
    ST_T_LINK,
    ST_T_WALK,
    ST_T_FETCH,
    ST_T_RESULT,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/rrss_ram.sv
// ============================================================================
// rrss_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module rrss_ram
  import rrss_pkg::*;
#(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = MAX_THREADS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/round_robin_sleep_scheduler.sv
// ============================================================================
// round_robin_sleep_scheduler: thread table with round-robin pick and sleep
// Creates threads into a linked ring and picks the next runnable thread.
// ============================================================================
// Each transaction gives one result. A create reads the running slot's link,
// writes the new slot and splices it in; a table-full create or an unused
// action goes straight to its result. A tick or sleep reads the running
// slot's link, walks the ring and fetches the chosen context, unless nothing
// is runnable and there is no idle thread: the walk follows the next-slot
// link memory one slot per cycle, feeding the stored wake time of each slot
// through one shared 64-bit compare against now. The input is taken only
// while the sequencer is idle; a finished result waits in the output register
// and does not block the next transaction from being accepted.
module round_robin_sleep_scheduler
  import rrss_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int UW = $clog2(MAX_THREADS + 1);
  localparam logic [IW-1:0] IDLE_SLOT = IW'(1);
  localparam logic [UW-1:0] CNT_MAX   = UW'(MAX_THREADS);
  localparam logic [UW-1:0] CNT_ONE   = UW'(1);
  localparam logic [UW-1:0] CNT_TWO   = UW'(2);

  // Control state
  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IW-1:0]   running_r, running_nxt;
  logic [UW-1:0]   slots_used_r, slots_used_nxt;
  logic            sleeping_r [MAX_THREADS];

  // Payload state
  out_item_t       out_data_r, out_data_nxt;
  out_item_t       res_r, res_nxt;
  logic [1:0]      act_r, act_nxt;
  logic [WORD_W-1:0] ctx_in_r, ctx_in_nxt;
  logic [WORD_W-1:0] now_r, now_nxt;
  logic [WORD_W-1:0] wake_in_r, wake_in_nxt;
  logic [IW-1:0]   start_r, start_nxt;
  logic [IW-1:0]   s_r, s_nxt;
  logic [IW-1:0]   pick_r, pick_nxt;
  logic            found_r, found_nxt;
  logic            cur_woken_r, cur_woken_nxt;
  logic            same_r, same_nxt;

  // Memory ports
  logic              link_we;
  logic [IW-1:0]     link_waddr, link_wdata, link_raddr, link_rdata;
  logic              wake_we;
  logic [IW-1:0]     wake_waddr;
  logic [WORD_W-1:0] wake_wdata, wake_rdata;
  logic              ctx_we;
  logic [IW-1:0]     ctx_waddr, ctx_raddr;
  logic [WORD_W-1:0] ctx_wdata, ctx_rdata;

  // Sleep flag write port
  logic              slp_we;
  logic [IW-1:0]     slp_waddr;
  logic              slp_wdata;

  // Walk helpers
  logic              have_idle;
  logic [IW-1:0]     lk;
  logic [IW-1:0]     ns;
  logic              is_cur, cur_sleep, eff_sleep, due, runnable;
  logic [WORD_W-1:0] eff_wake;
  logic [IW-1:0]     pk;

  rrss_ram #(.WIDTH(IW), .DEPTH(MAX_THREADS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  rrss_ram #(.WIDTH(WORD_W), .DEPTH(MAX_THREADS)) u_wake_ram (
    .clk(clk), .we(wake_we), .waddr(wake_waddr), .wdata(wake_wdata),
    .raddr(link_raddr), .rdata(wake_rdata)
  );

  rrss_ram #(.WIDTH(WORD_W), .DEPTH(MAX_THREADS)) u_ctx_ram (
    .clk(clk), .we(ctx_we), .waddr(ctx_waddr), .wdata(ctx_wdata),
    .raddr(ctx_raddr), .rdata(ctx_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only slot 0 exists until the first create; its link points to itself
  assign have_idle = (slots_used_r >= CNT_TWO);
  assign lk        = (slots_used_r == CNT_ONE) ? '0 : link_rdata;
  assign ns        = slots_used_r[IW-1:0];

  // Shared wake compare on the slot under walk
  assign is_cur    = (s_r == running_r);
  assign cur_sleep = is_cur && (act_r == ACT_SLEEP);
  assign eff_sleep = cur_sleep || sleeping_r[s_r];
  assign eff_wake  = cur_sleep ? wake_in_r : wake_rdata;
  assign due       = (now_r >= eff_wake);
  assign runnable  = (!eff_sleep || due) && !(have_idle && (s_r == IDLE_SLOT));

  assign pk = found_r ? pick_r : IDLE_SLOT;

  // Sequencer: next state, memory controls and result assembly
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    running_nxt    = running_r;
    slots_used_nxt = slots_used_r;
    res_nxt        = res_r;
    act_nxt        = act_r;
    ctx_in_nxt     = ctx_in_r;
    now_nxt        = now_r;
    wake_in_nxt    = wake_in_r;
    start_nxt      = start_r;
    s_nxt          = s_r;
    pick_nxt       = pick_r;
    found_nxt      = found_r;
    cur_woken_nxt  = cur_woken_r;
    same_nxt       = same_r;

    link_we    = 1'b0;
    link_waddr = running_r;
    link_wdata = ns;
    link_raddr = running_r;
    wake_we    = 1'b0;
    wake_waddr = running_r;
    wake_wdata = wake_in_r;
    ctx_we     = 1'b0;
    ctx_waddr  = running_r;
    ctx_wdata  = ctx_in_r;
    ctx_raddr  = pk;
    slp_we     = 1'b0;
    slp_waddr  = s_r;
    slp_wdata  = 1'b0;

    // Drop the output once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_data.action;
          ctx_in_nxt  = in_data.context_word;
          now_nxt     = in_data.now;
          wake_in_nxt = in_data.wake_time;
          res_nxt.slot           = SLOT_W'(running_r);
          res_nxt.resume_context = '0;
          res_nxt.ran_idle       = 1'b0;
          res_nxt.status         = STS_OK;
          case (in_data.action)
            ACT_CREATE: begin
              if (slots_used_r >= CNT_MAX) begin
                res_nxt.status = STS_FULL;
                state_nxt      = ST_EMIT;
              end else begin
                state_nxt = ST_CR_RD;
              end
            end
            ACT_TICK, ACT_SLEEP: begin
              state_nxt = ST_T_START;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // Create: fetch the running slot's link, splice the new slot in after it
      ST_CR_RD: begin
        link_raddr = running_r;
        state_nxt  = ST_CR_WR1;
      end

      ST_CR_WR1: begin
        link_we    = 1'b1;
        link_waddr = ns;
        link_wdata = lk;
        ctx_we     = 1'b1;
        ctx_waddr  = ns;
        wake_we    = 1'b1;
        wake_waddr = ns;
        wake_wdata = '0;
        slp_we     = 1'b1;
        slp_waddr  = ns;
        state_nxt  = ST_CR_WR2;
      end

      ST_CR_WR2: begin
        link_we        = 1'b1;
        link_waddr     = running_r;
        link_wdata     = ns;
        slots_used_nxt = slots_used_r + CNT_ONE;
        res_nxt.slot   = SLOT_W'(ns);
        state_nxt      = ST_EMIT;
      end

      // Tick: read the running slot's link to find where the walk starts
      ST_T_START: begin
        link_raddr = running_r;
        state_nxt  = ST_T_LINK;
      end

      ST_T_LINK: begin
        link_raddr    = lk;
        start_nxt     = lk;
        s_nxt         = lk;
        found_nxt     = 1'b0;
        cur_woken_nxt = 1'b0;
        state_nxt     = ST_T_WALK;
      end

      // Walk one slot per cycle: wake if due, stop at the first runnable one
      ST_T_WALK: begin
        link_raddr = lk;
        if (eff_sleep && due) begin
          slp_we    = 1'b1;
          slp_waddr = s_r;
          if (is_cur) begin
            cur_woken_nxt = 1'b1;
          end
        end
        if (runnable) begin
          found_nxt = 1'b1;
          pick_nxt  = s_r;
          state_nxt = ST_T_FETCH;
        end else if (lk == start_r) begin
          state_nxt = ST_T_FETCH;
        end else begin
          s_nxt = lk;
        end
      end

      // Commit the save and sleep mark, read the chosen context
      ST_T_FETCH: begin
        if (found_r || have_idle) begin
          ctx_raddr = pk;
          ctx_we    = 1'b1;
          if (act_r == ACT_SLEEP) begin
            wake_we   = 1'b1;
            slp_we    = 1'b1;
            slp_waddr = running_r;
            slp_wdata = !cur_woken_r;
          end
          running_nxt      = pk;
          same_nxt         = (pk == running_r);
          res_nxt.slot     = SLOT_W'(pk);
          res_nxt.ran_idle = !found_r;
          state_nxt        = ST_T_RESULT;
        end else begin
          res_nxt.status = STS_NO_RUN;
          state_nxt      = ST_EMIT;
        end
      end

      // Bypass the just-saved word when the same slot resumes
      ST_T_RESULT: begin
        res_nxt.resume_context = same_r ? ctx_in_r : ctx_rdata;
        state_nxt              = ST_EMIT;
      end

      // Hold the result until the output register is free
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      running_r    <= '0;
      slots_used_r <= CNT_ONE;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      running_r    <= running_nxt;
      slots_used_r <= slots_used_nxt;
    end
  end

  // Sleep flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        sleeping_r[i] <= 1'b0;
      end
    end else if (slp_we) begin
      sleeping_r[slp_waddr] <= slp_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    res_r       <= res_nxt;
    act_r       <= act_nxt;
    ctx_in_r    <= ctx_in_nxt;
    now_r       <= now_nxt;
    wake_in_r   <= wake_in_nxt;
    start_r     <= start_nxt;
    s_r         <= s_nxt;
    pick_r      <= pick_nxt;
    found_r     <= found_nxt;
    cur_woken_r <= cur_woken_nxt;
    same_r      <= same_nxt;
  end

  // Checks
  a_slots_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slots_used_r >= CNT_ONE) && (slots_used_r <= CNT_MAX))
    else $error("slot count out of range");

  a_running_exists: assert property (@(posedge clk) disable iff (!rst_n)
    UW'(running_r) < slots_used_r)
    else $error("running slot not in table");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T_WALK) |-> (UW'(s_r) < slots_used_r))
    else $error("walk left the table");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ran_idle) |->
      (out_data.status == STS_OK && out_data.slot == SLOT_W'(IDLE_SLOT)))
    else $error("idle fallback result malformed");

  a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CR_WR2) |=> (slots_used_r == $past(slots_used_r) + CNT_ONE))
    else $error("create did not add a slot");

endmodule

>>> tb/round_robin_sleep_scheduler_checker.sv
// ============================================================================
// round_robin_sleep_scheduler_checker: dispatch predictor and result compare
// Watches both channels of the scheduler. Each accepted transaction runs
// through a private copy of the thread table, ring links and sleep marks, and
// the expected dispatch is queued. Each accepted result is checked field by
// field against the oldest queued dispatch.
// ============================================================================
module round_robin_sleep_scheduler_checker
  import rrss_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // The first created slot is the idle thread
  localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(1);

  // Shadow thread table
  logic [WORD_W-1:0] thread_ctx [MAX_THREADS];
  logic [WORD_W-1:0] wake_tab   [MAX_THREADS];
  bit                asleep     [MAX_THREADS];
  logic [SLOT_W-1:0] ring_link  [MAX_THREADS];
  logic [SLOT_W-1:0] cur_slot;
  int                used_count;

  out_item_t dispatch_q [$];
  out_item_t want;

  // Apply one transaction to the shadow table and return its dispatch
  function automatic out_item_t predict_dispatch(in_item_t it);
    out_item_t         res;
    logic [SLOT_W-1:0] ns;
    logic [SLOT_W-1:0] start;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] pick;
    logic [WORD_W-1:0] prev_ctx;
    logic [WORD_W-1:0] prev_wake;
    bit                prev_asleep;
    bit                has_idle;
    bit                found;
    bit                done;
    int                n;
    res      = '0;
    res.slot = cur_slot;
    pick     = '0;
    case (it.action)
      ACT_CREATE: begin
        if (used_count >= MAX_THREADS) begin
          res.status = STS_FULL;
        end else begin
          // Link the new slot in right after the running one
          ns                  = SLOT_W'(used_count);
          thread_ctx[ns]      = it.context_word;
          asleep[ns]          = 1'b0;
          wake_tab[ns]        = '0;
          ring_link[ns]       = ring_link[cur_slot];
          ring_link[cur_slot] = ns;
          used_count++;
          res.slot = ns;
        end
      end
      ACT_TICK, ACT_SLEEP: begin
        prev_ctx    = thread_ctx[cur_slot];
        prev_wake   = wake_tab[cur_slot];
        prev_asleep = asleep[cur_slot];
        has_idle    = used_count >= 2;
        if (it.action == ACT_SLEEP) begin
          asleep[cur_slot]   = 1'b1;
          wake_tab[cur_slot] = it.wake_time;
        end
        thread_ctx[cur_slot] = it.context_word;

        // Walk the ring once, waking due sleepers, until a runnable thread
        start = ring_link[cur_slot];
        s     = start;
        found = 1'b0;
        done  = 1'b0;
        n     = 0;
        while (!done) begin
          if (asleep[s] && it.now >= wake_tab[s]) asleep[s] = 1'b0;
          if (!asleep[s] && !(has_idle && s == IDLE_SLOT)) begin
            found = 1'b1;
            pick  = s;
            done  = 1'b1;
          end else begin
            s = ring_link[s];
            n++;
            if (s == start || n >= MAX_THREADS) done = 1'b1;
          end
        end

        if (found) begin
          cur_slot           = pick;
          res.slot           = pick;
          res.resume_context = thread_ctx[pick];
        end else if (has_idle) begin
          cur_slot           = IDLE_SLOT;
          res.slot           = IDLE_SLOT;
          res.resume_context = thread_ctx[IDLE_SLOT];
          res.ran_idle       = 1'b1;
        end else begin
          // Nothing runnable and no idle thread: undo the save and the mark
          thread_ctx[cur_slot] = prev_ctx;
          wake_tab[cur_slot]   = prev_wake;
          asleep[cur_slot]     = prev_asleep;
          res.status           = STS_NO_RUN;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare results first, then queue the new transaction's dispatch
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        thread_ctx[i] = '0;
        wake_tab[i]   = '0;
        asleep[i]     = 1'b0;
        ring_link[i]  = '0;
      end
      cur_slot   = '0;
      used_count = 1;
      fail_count = 0;
      dispatch_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (dispatch_q.size() == 0) begin
          $error("result with no transaction outstanding: slot %0d status %0d",
                 out_data.slot, out_data.status);
          fail_count++;
        end else begin
          want = dispatch_q.pop_front();
          check_field("slot", WORD_W'(want.slot), WORD_W'(out_data.slot));
          check_field("resume_context", want.resume_context, out_data.resume_context);
          check_field("ran_idle", WORD_W'(want.ran_idle), WORD_W'(out_data.ran_idle));
          check_field("status", WORD_W'(want.status), WORD_W'(out_data.status));
        end
      end
      if (in_valid && in_ready) dispatch_q.push_back(predict_dispatch(in_data));
    end
    pending = dispatch_q.size();
  end

endmodule

>>> tb/tb_round_robin_sleep_scheduler.sv
// ============================================================================
// tb_round_robin_sleep_scheduler: stimulus and verdict for the scheduler
// Drives directed create, tick and sleep transactions through the corner
// cases, then random scheduling traffic under three idling profiles and one
// long output hold-off. A checker beside the block predicts and compares.
// ============================================================================
module tb_round_robin_sleep_scheduler;
  import rrss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         RAND_ITEMS     = 1275;
  localparam int         RX_HOLD_CYCLES = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  bit rx_hold_req   = 1'b0;
  int stall_cycles  = 0;
  logic [WORD_W-1:0] tick_base = '0;

  round_robin_sleep_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  round_robin_sleep_scheduler_checker sched_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t make_item(logic [1:0] act, logic [WORD_W-1:0] ctx,
                                         logic [WORD_W-1:0] now_v,
                                         logic [WORD_W-1:0] wake_v);
    in_item_t it;
    it.action       = act;
    it.context_word = ctx;
    it.now          = now_v;
    it.wake_time    = wake_v;
    return it;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Advance system time, then build a mostly well-formed scheduling event
  function automatic in_item_t random_event();
    int                roll;
    int                wroll;
    logic [1:0]        act;
    logic [WORD_W-1:0] now_v;
    logic [WORD_W-1:0] wake_v;
    if ($urandom_range(0, 49) == 0) tick_base += WORD_W'($urandom_range(100, 1000));
    else tick_base += WORD_W'($urandom_range(0, 3));
    now_v = ($urandom_range(0, 19) == 0) ? rand_word() : tick_base;
    wroll = $urandom_range(0, 19);
    if (wroll == 0) wake_v = rand_word();
    else if (wroll == 1) wake_v = tick_base - WORD_W'($urandom_range(0, 5));
    else wake_v = tick_base + WORD_W'($urandom_range(1, 80));
    roll = $urandom_range(0, 99);
    if (roll < 4) act = ACT_CREATE;
    else if (roll < 7) act = ACT_UNUSED;
    else if (roll < 52) act = ACT_SLEEP;
    else act = ACT_TICK;
    return make_item(act, rand_word(), now_v, wake_v);
  endfunction

  // Offer one transaction, idling first at random, and hold until accepted
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready   <= 1'b0;
        rx_hold_req = 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner cases from reset up to a full table
    in_gap_pct    = 28;
    out_stall_pct = 74;
    send_item(make_item(ACT_SLEEP, ALL_ONES, '0, ALL_ONES));   // nothing runnable, no idle
    send_item(make_item(ACT_TICK, '0, '0, '0));                // main thread alone
    send_item(make_item(ACT_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES));
    send_item(make_item(ACT_SLEEP, rand_word(), '0, '0));      // already due, runs again
    send_item(make_item(ACT_CREATE, rand_word(), '0, '0));     // idle thread
    send_item(make_item(ACT_TICK, rand_word(), WORD_W'(5), '0));
    // fall back to idle
    send_item(make_item(ACT_SLEEP, rand_word(), WORD_W'(10), WORD_W'(100)));
    // idle asleep, still picked
    send_item(make_item(ACT_SLEEP, rand_word(), WORD_W'(20), ALL_ONES));
    send_item(make_item(ACT_TICK, rand_word(), ALL_ONES, '0)); // wake main at end of time
    for (int i = 0; i < 15; i++) begin
      send_item(make_item(ACT_CREATE, rand_word(), '0, '0));   // last one hits a full table
      if (i % 7 == 6) send_item(make_item(ACT_TICK, rand_word(), WORD_W'(30), '0));
    end

    // Random: three idling profiles, long hold-off at the start of the last
    tick_base = WORD_W'(1000);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_gap_pct    = 28;
          out_stall_pct = 74;
        end
        1: begin
          in_gap_pct    = 74;
          out_stall_pct = 28;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
          rx_hold_req   = 1'b1;
        end
      endcase
      for (int k = 0; k < RAND_ITEMS / 3; k++) send_item(random_event());
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for stray ones
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
